/* hw/rtl/sha256_stream_hasher_top_assert.svh */
// Assertion macros used by the top-level RTL file.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Implication or plain property, checked at each clock when out of reset.
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sha assertion failed");
// Condition that must never hold.
`define SHA_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sha forbidden condition");
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic       ACT_ABSORB = 1'b0;
  localparam logic       ACT_FINISH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PRIME = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // How the 16 schedule words of the block being compressed are sourced
  typedef struct packed {
    logic [4:0] ram_words;
    logic       has_pad;
    logic       use_len;
  } blk_src_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sm_s0(input logic [31:0] x);
    sm_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sm_s1(input logic [31:0] x);
    sm_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* hw/rtl/sha256_stream_hasher_top.sv */
`timescale 1ns / 1ps
// Channel | Dir | Ports                                         | Request
// in      | in  | in_valid in_stall in_action in_data_byte      | absorb byte / finish
// out     | out | out_valid out_stall out_digest_index          | one digest word
//         |     | out_digest_word out_digest_last               |
// An absorb byte is taken while idle; the 64th byte of a block starts its compression.
// Finish compresses the padded last block (two blocks when fill is above 55), then emits 8 output words.
// Compression is one round per cycle, words streamed from the block RAM.
// Synchronous active-low reset clears control and length state and loads the initial chaining value.
// in_stall is high whenever the block is compressing or emitting; out_stall holds words.
`include "sha256_stream_hasher_top_assert.svh"
module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_digest_index,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  state_t      state_r, state_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] padw_r, padw_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  blk_src_t    src_r, src_nxt;
  logic        second_r, second_nxt;
  logic        finish_r, finish_nxt;

  logic        in_acc, out_acc;
  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic [31:0] sched_w, load_w, cur_w, t1, t2;
  logic [31:0] pad_word;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_digest_index = idx_r;
  assign out_digest_word  = chain_r[idx_r];
  assign out_digest_last  = (idx_r == 3'd7);

  sha_ram #(.Width(32), .Depth(16)) u_blk (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // byte packing: a word goes to RAM when its fourth byte arrives
  assign ram_we    = in_acc && (in_action == ACT_ABSORB) && (fill_r[1:0] == 2'd3);
  assign ram_waddr = fill_r[5:2];
  assign ram_wdata = {acc_r[31:8], in_data_byte};
  assign ram_raddr = (state_r == ST_ROUND) ? (rnd_r[3:0] + 4'd1) : 4'd0;

  // pad word: bytes so far in the word, then 0x80, then zeros
  always_comb begin
    case (fill_r[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc_r[31:24], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc_r[31:16], PAD_BYTE, 8'h0};
      default: pad_word = {acc_r[31:8], PAD_BYTE};
    endcase
  end

  // source of the first sixteen words
  always_comb begin
    if ({1'b0, rnd_r[3:0]} < src_r.ram_words) begin
      load_w = ram_rdata;
    end else if (src_r.has_pad && ({1'b0, rnd_r[3:0]} == src_r.ram_words)) begin
      load_w = padw_r;
    end else begin
      load_w = 32'h0;
    end
    if (src_r.use_len && (rnd_r[3:0] == 4'd14)) begin
      load_w = bits_r[63:32];
    end else if (src_r.use_len && (rnd_r[3:0] == 4'd15)) begin
      load_w = bits_r[31:0];
    end
  end

  // schedule expansion and round
  assign sched_w = w_r[0] + sm_s0(w_r[1]) + w_r[9] + sm_s1(w_r[14]);
  assign cur_w   = (rnd_r < 6'd16) ? load_w : sched_w;
  assign t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[rnd_r] + cur_w;
  assign t2 = big_s0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // control and datapath next state
  always_comb begin
    state_nxt  = state_r;
    chain_nxt  = chain_r;
    v_nxt      = v_r;
    w_nxt      = w_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    acc_nxt    = acc_r;
    padw_nxt   = padw_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    src_nxt    = src_r;
    second_nxt = second_r;
    finish_nxt = finish_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_action == ACT_ABSORB)) begin
          case (fill_r[1:0])
            2'd0:    acc_nxt[31:24] = in_data_byte;
            2'd1:    acc_nxt[23:16] = in_data_byte;
            2'd2:    acc_nxt[15:8]  = in_data_byte;
            default: acc_nxt[7:0]   = in_data_byte;
          endcase
          fill_nxt = fill_r + 6'd1;
          bits_nxt = bits_r + 64'd8;
          if (fill_r == 6'd63) begin
            src_nxt   = '{ram_words: 5'd16, has_pad: 1'b0, use_len: 1'b0};
            state_nxt = ST_PRIME;
          end
        end else if (in_acc) begin
          padw_nxt   = pad_word;
          src_nxt    = '{ram_words: {1'b0, fill_r[5:2]}, has_pad: 1'b1,
                         use_len: (fill_r <= 6'd55)};
          second_nxt = (fill_r > 6'd55);
          finish_nxt = 1'b1;
          state_nxt  = ST_PRIME;
        end
      end
      ST_PRIME: begin
        v_nxt     = chain_r;
        rnd_nxt   = 6'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = cur_w;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        if (second_r) begin
          second_nxt = 1'b0;
          src_nxt    = '{ram_words: 5'd0, has_pad: 1'b0, use_len: 1'b1};
          state_nxt  = ST_PRIME;
        end else if (finish_r) begin
          idx_nxt   = 3'd0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            chain_nxt  = INIT_H;
            fill_nxt   = 6'd0;
            bits_nxt   = 64'd0;
            finish_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      chain_r  <= INIT_H;
      fill_r   <= 6'd0;
      bits_r   <= 64'd0;
      rnd_r    <= 6'd0;
      idx_r    <= 3'd0;
      second_r <= 1'b0;
      finish_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      chain_r  <= chain_nxt;
      fill_r   <= fill_nxt;
      bits_r   <= bits_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      second_r <= second_nxt;
      finish_r <= finish_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    w_r    <= w_nxt;
    acc_r  <= acc_nxt;
    padw_r <= padw_nxt;
    src_r  <= src_nxt;
  end

  `SHA_NEVER(a_no_in_while_out, clk, rst_n, out_valid && in_acc)
  `SHA_ASSERT(a_add_after_last_round, clk, rst_n, (state_r == ST_ADD) |-> ($past(rnd_r) == 6'd63))
  `SHA_ASSERT(a_clear_after_last, clk, rst_n, (out_acc && out_digest_last) |=> (fill_r == 6'd0 && bits_r == 64'd0))
  `SHA_NEVER(a_second_only_finishing, clk, rst_n, second_r && !finish_r)

endmodule

/* hw/rtl/sha_ram.sv */
`timescale 1ns / 1ps
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
